// File: src/utpw_pkg.sv
// ----------------------------------------------------------------------------
// utpw_pkg - shared types and helpers for the text page line wrapper
// Event and result records, configuration record, character class tables.
// ----------------------------------------------------------------------------
`default_nettype none

package utpw_pkg;

   localparam int ROW_GLYPHS  = 32;
   localparam int IDX_W       = $clog2(ROW_GLYPHS);
   localparam int FILL_W      = $clog2(ROW_GLYPHS + 1);
   localparam int OFFSET_BITS = 32;

   localparam logic [20:0] CP_REPL   = 21'h00FFFD;
   localparam logic [20:0] CP_MAX    = 21'h10FFFF;
   localparam logic [20:0] CP_SUR_LO = 21'h00D800;
   localparam logic [20:0] CP_SUR_HI = 21'h00DFFF;
   localparam logic [20:0] CP_BOM    = 21'h00FEFF;
   localparam logic [20:0] CP_IDSP   = 21'h003000;
   localparam logic [20:0] CP_TAB    = 21'h000009;
   localparam logic [20:0] CP_LF     = 21'h00000A;
   localparam logic [20:0] CP_CR     = 21'h00000D;
   localparam logic [20:0] CP_SPACE  = 21'h000020;
   localparam logic [20:0] CP_DEL    = 21'h00007F;

   localparam logic [1:0] OP_START = 2'd0;
   localparam logic [1:0] OP_BYTE  = 2'd1;
   localparam logic [1:0] OP_EOD   = 2'd2;

   localparam logic [1:0] CSR_WIDTH = 2'd0;
   localparam logic [1:0] CSR_ROWS  = 2'd1;
   localparam logic [1:0] CSR_PITCH = 2'd2;
   localparam logic [1:0] CSR_LIMIT = 2'd3;

   typedef enum logic [1:0] {
      EV_START,
      EV_PLACE,
      EV_EOD
   } ev_kind_type;

   typedef struct packed {
      ev_kind_type            kind;
      logic [20:0]            code;
      logic [OFFSET_BITS-1:0] char_ofs;
      logic [OFFSET_BITS-1:0] next;
      logic                   eod_place;
   } ev_type;

   typedef struct packed {
      logic [7:0] width;
      logic [3:0] rows;
      logic [4:0] pitch;
      logic [7:0] limit;
   } cfg_type;

   typedef struct packed {
      logic                   kind;
      logic [20:0]            code;
      logic [7:0]             x;
      logic [7:0]             y;
      logic [7:0]             total;
      logic [OFFSET_BITS-1:0] next;
      logic                   last;
   } res_type;

   typedef enum logic [3:0] {
      B_IDLE, B_DISPATCH, B_FILTER, B_NLDONE, B_SCANCL, B_SCANOP, B_SUM, B_DECIDE,
      B_WRAPROW, B_WRAPFIN, B_MOVE, B_LIMIT, B_EMIT, B_FIN, B_EODFIN, B_END
   } bstate_type;

   function automatic logic [3:0] glyph_w(input logic [20:0] c);
      return (c < 21'd128) ? 4'd6 : 4'd12;
   endfunction

   function automatic logic is_closing(input logic [20:0] c);
      logic r;
      case (c)
         21'h2C, 21'h2E, 21'h21, 21'h3F, 21'h3A, 21'h3B, 21'h29, 21'h5D, 21'h7D,
         21'hFF0C, 21'h3002, 21'h3001, 21'hFF01, 21'hFF1F, 21'hFF1A, 21'hFF1B,
         21'h201D, 21'h2019, 21'hFF09, 21'h300B, 21'h3009, 21'h3011, 21'h300D,
         21'h300F, 21'h2026: r = 1'b1;
         default: r = 1'b0;
      endcase
      return r;
   endfunction

   function automatic logic is_opening(input logic [20:0] c);
      logic r;
      case (c)
         21'h28, 21'h5B, 21'h7B, 21'h201C, 21'h2018, 21'hFF08, 21'h300A,
         21'h3008, 21'h3010, 21'h300C, 21'h300E: r = 1'b1;
         default: r = 1'b0;
      endcase
      return r;
   endfunction

   function automatic logic [20:0] min_code(input logic [1:0] cls);
      logic [20:0] r;
      case (cls)
         2'd1:    r = 21'h80;
         2'd2:    r = 21'h800;
         2'd3:    r = 21'h10000;
         default: r = 21'h0;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// File: src/utf8_text_page_line_wrapper.sv
// ----------------------------------------------------------------------------
// utf8_text_page_line_wrapper - UTF-8 page layout with kinsoku line breaking
// Decodes text bytes, lays glyphs into rows, streams placed glyphs and a
// page-finished beat with glyph count and next page offset.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_ready  | op, data_byte, start_offset
//  rsp     | out       | rsp_valid/rsp_ready  | kind, glyph_code/x/y, total, next, last
//  csr     | in        | csr_we               | csr_index, csr_wdata
//
//  Layout sequencer steps per beat: start (pop, dispatch, end); dropped
//  character (pop, dispatch, filter, end); glyph placed without a wrap (pop,
//  dispatch, filter, limit, end). A wrap walks the row buffer one entry per
//  cycle (single port) for scan, width sum, emit and shift; emit waits on rsp.
//  Results are emitted one per cycle while rsp_ready is high.
//  Reset is synchronous; page idle, registers at defaults. rsp stalls back up
//  the two-entry event queue, then req_ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_text_page_line_wrapper (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [1:0]                       req_op,
   input  wire logic [7:0]                       req_data_byte,
   input  wire logic [utpw_pkg::OFFSET_BITS-1:0] req_start_offset,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic                                  rsp_kind,
   output logic [20:0]                           rsp_glyph_code,
   output logic [7:0]                            rsp_glyph_x,
   output logic [7:0]                            rsp_glyph_y,
   output logic [7:0]                            rsp_glyph_total,
   output logic [utpw_pkg::OFFSET_BITS-1:0]      rsp_next_offset,
   output logic                                  rsp_last,
   input  wire logic                             csr_we,
   input  wire logic [1:0]                       csr_index,
   input  wire logic [7:0]                       csr_wdata
);
   import utpw_pkg::*;

   cfg_type cfg_ff, cfg_in;
   ev_type  ev_push_data, q_data;
   logic    ev_push, q_pop, q_full, q_empty;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_WIDTH: cfg_in.width = csr_wdata;
            CSR_ROWS:  cfg_in.rows  = csr_wdata[3:0];
            CSR_PITCH: cfg_in.pitch = csr_wdata[4:0];
            CSR_LIMIT: cfg_in.limit = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{width: 8'd126, rows: 4'd4, pitch: 5'd13, limit: 8'd84};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: decode and classify
   utpw_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (req_op),
      .req_data_byte    (req_data_byte),
      .req_start_offset (req_start_offset),
      .q_full           (q_full),
      .ev_push          (ev_push),
      .ev_out           (ev_push_data)
   );

   // decoupling queue
   utpw_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (ev_push),
      .push_data (ev_push_data),
      .pop       (q_pop),
      .pop_data  (q_data),
      .full      (q_full),
      .empty     (q_empty)
   );

   // back: row layout and result stream
   utpw_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .q_empty         (q_empty),
      .q_data          (q_data),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_glyph_code  (rsp_glyph_code),
      .rsp_glyph_x     (rsp_glyph_x),
      .rsp_glyph_y     (rsp_glyph_y),
      .rsp_glyph_total (rsp_glyph_total),
      .rsp_next_offset (rsp_next_offset),
      .rsp_last        (rsp_last)
   );

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      ev_push |-> !q_full) else $error("event queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty) else $error("event queue underflow");
   a_fin_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind) |-> rsp_last) else $error("page beat not last");
   a_fin_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind) |-> (rsp_glyph_code == 21'd0 && rsp_glyph_x == 8'd0))
      else $error("page beat carries glyph data");
`endif

endmodule

`default_nettype wire

// File: src/utpw_front.sv
// ----------------------------------------------------------------------------
// utpw_front - input side: UTF-8 decoder and byte offset tracking
// Turns accepted beats into start, place and end-of-data events.
// ----------------------------------------------------------------------------
`default_nettype none

module utpw_front (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [1:0]                       req_op,
   input  wire logic [7:0]                       req_data_byte,
   input  wire logic [utpw_pkg::OFFSET_BITS-1:0] req_start_offset,
   input  wire logic                             q_full,
   output logic                                  ev_push,
   output utpw_pkg::ev_type                      ev_out
);
   import utpw_pkg::*;

   logic [OFFSET_BITS-1:0] bpos_ff, bpos_in, cstart_ff, cstart_in;
   logic [1:0]             pend_ff, pend_in, cls_ff, cls_in;
   logic [20:0]            part_ff, part_in;
   logic [20:0]            part_new;
   logic [7:0]             b;

   assign req_ready = !q_full;
   assign b         = req_data_byte;
   assign part_new  = {part_ff[14:0], b[5:0]};

   always_comb begin
      bpos_in   = bpos_ff;
      cstart_in = cstart_ff;
      pend_in   = pend_ff;
      cls_in    = cls_ff;
      part_in   = part_ff;
      ev_push   = 1'b0;
      ev_out    = '{kind: EV_PLACE, code: CP_REPL, char_ofs: cstart_ff,
                    next: bpos_ff, eod_place: 1'b0};
      if (req_valid && req_ready) begin
         unique case (req_op)
            OP_START: begin
               bpos_in     = req_start_offset;
               cstart_in   = req_start_offset;
               pend_in     = 2'd0;
               cls_in      = 2'd0;
               part_in     = '0;
               ev_push     = 1'b1;
               ev_out.kind = EV_START;
            end
            OP_BYTE: begin
               bpos_in = bpos_ff + 1'b1;
               if (pend_ff == 2'd0) begin
                  cstart_in       = bpos_ff;
                  ev_out.char_ofs = bpos_ff;
                  if (b < 8'h80) begin
                     ev_push     = 1'b1;
                     ev_out.code = {13'd0, b};
                  end else if (b >= 8'hC2 && b <= 8'hDF) begin
                     pend_in = 2'd1; part_in = {16'd0, b[4:0]}; cls_in = 2'd1;
                  end else if (b >= 8'hE0 && b <= 8'hEF) begin
                     pend_in = 2'd2; part_in = {17'd0, b[3:0]}; cls_in = 2'd2;
                  end else if (b >= 8'hF0 && b <= 8'hF4) begin
                     pend_in = 2'd3; part_in = {18'd0, b[2:0]}; cls_in = 2'd3;
                  end else begin
                     ev_push = 1'b1;
                  end
               end else if (b[7:6] != 2'b10) begin
                  pend_in = 2'd0;
                  ev_push = 1'b1;
               end else begin
                  part_in = part_new;
                  pend_in = pend_ff - 2'd1;
                  if (pend_ff == 2'd1) begin
                     ev_push = 1'b1;
                     if (part_new < min_code(cls_ff) || part_new > CP_MAX ||
                         (part_new >= CP_SUR_LO && part_new <= CP_SUR_HI))
                        ev_out.code = CP_REPL;
                     else
                        ev_out.code = part_new;
                  end
               end
            end
            OP_EOD: begin
               pend_in          = 2'd0;
               ev_push          = 1'b1;
               ev_out.kind      = EV_EOD;
               ev_out.eod_place = (pend_ff != 2'd0);
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bpos_ff   <= '0;
         cstart_ff <= '0;
         pend_ff   <= 2'd0;
         cls_ff    <= 2'd0;
         part_ff   <= '0;
      end else begin
         bpos_ff   <= bpos_in;
         cstart_ff <= cstart_in;
         pend_ff   <= pend_in;
         cls_ff    <= cls_in;
         part_ff   <= part_in;
      end
   end

endmodule

`default_nettype wire

// File: src/utpw_queue.sv
// ----------------------------------------------------------------------------
// utpw_queue - two-entry event queue between decoder and layout engine
// ----------------------------------------------------------------------------
`default_nettype none

module utpw_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  utpw_pkg::ev_type      push_data,
   input  wire logic             pop,
   output utpw_pkg::ev_type      pop_data,
   output logic                  full,
   output logic                  empty
);
   import utpw_pkg::*;

   ev_type     store_ff [2];
   logic       wptr_ff, rptr_ff;
   logic [1:0] cnt_ff;

   assign full     = (cnt_ff == 2'd2);
   assign empty    = (cnt_ff == 2'd0);
   assign pop_data = store_ff[rptr_ff];

   always_ff @(posedge clock) begin
      if (push) store_ff[wptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         if (push) wptr_ff <= !wptr_ff;
         if (pop)  rptr_ff <= !rptr_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

endmodule

`default_nettype wire

// File: src/utpw_back.sv
// ----------------------------------------------------------------------------
// utpw_back - layout engine: row buffer, kinsoku wrap and result output
// Sequencer walks the row buffer one entry per cycle unless emit is held;
// results leave through a one-deep hold stage and an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module utpw_back (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  utpw_pkg::cfg_type                     cfg,
   input  wire logic                             q_empty,
   input  utpw_pkg::ev_type                      q_data,
   output logic                                  q_pop,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic                                  rsp_kind,
   output logic [20:0]                           rsp_glyph_code,
   output logic [7:0]                            rsp_glyph_x,
   output logic [7:0]                            rsp_glyph_y,
   output logic [7:0]                            rsp_glyph_total,
   output logic [utpw_pkg::OFFSET_BITS-1:0]      rsp_next_offset,
   output logic                                  rsp_last
);
   import utpw_pkg::*;

   bstate_type             state_ff, state_in, ret_ff, ret_in;
   ev_type                 ev_ff, ev_in;
   logic                   eod_ff, eod_in, active_ff, active_in;
   logic [7:0]             cursor_ff, cursor_in, count_ff, count_in, ex_ff, ex_in;
   logic [3:0]             row_ff, row_in, w_ff, w_in;
   logic [FILL_W-1:0]      fill_ff, fill_in, split_ff, split_in, idx_ff, idx_in;
   logic [FILL_W-1:0]      en_ff, en_in;
   logic [8:0]             moved_ff, moved_in;
   logic [20:0]            c_ff, c_in;
   logic [OFFSET_BITS-1:0] fnext_ff, fnext_in;

   logic [20:0]            codes_mem [ROW_GLYPHS];
   logic [OFFSET_BITS-1:0] offs_mem  [ROW_GLYPHS];
   logic                   wr_en;
   logic [IDX_W-1:0]       wr_addr, rd_addr;
   logic [20:0]            wr_code, rd_code;
   logic [OFFSET_BITS-1:0] wr_off, rd_off;

   res_type                hold_ff, hold_in, out_ff, out_in, prod_res;
   logic                   hold_v_ff, hold_v_in, rsp_v_ff, rsp_v_in;
   logic                   prod, flush, out_free, can_prod;

   logic [20:0]            ce;
   logic [3:0]             cw;
   logic                   ovf, row_full, wrap_last, dec_keep;
   logic [FILL_W-1:0]      mv_n, split_dec;
   logic [3:0]             row_inc;
   logic [8:0]             ymul;
   bstate_type             place_done;

   assign out_free   = !rsp_v_ff || rsp_ready;
   assign can_prod   = !hold_v_ff || out_free;
   assign ce         = (c_ff == CP_TAB) ? CP_SPACE : c_ff;
   assign cw         = glyph_w(ce);
   assign ovf        = (({1'b0, cursor_ff} + {5'd0, cw}) > {1'b0, cfg.width}) ||
                       (fill_ff >= FILL_W'(ROW_GLYPHS));
   assign row_full   = (row_ff >= cfg.rows);
   assign row_inc    = row_ff + 4'd1;
   assign wrap_last  = (row_inc >= cfg.rows);
   assign mv_n       = fill_ff - split_ff;
   assign dec_keep   = (split_ff == '0) ||
                       (({1'b0, moved_ff} + {6'd0, w_ff}) > {2'd0, cfg.width});
   assign split_dec  = dec_keep ? fill_ff : split_ff;
   assign ymul       = {5'd0, row_ff} * {4'd0, cfg.pitch};
   assign place_done = eod_ff ? B_EODFIN : B_END;
   assign q_pop      = (state_ff == B_IDLE) && !q_empty;

   // single read port, address picked by the sequencer step
   always_comb begin
      unique case (state_ff)
         B_SCANCL:  rd_addr = split_ff[IDX_W-1:0];
         B_SCANOP:  rd_addr = IDX_W'(split_ff - 1'b1);
         B_SUM:     rd_addr = idx_ff[IDX_W-1:0];
         B_WRAPFIN: rd_addr = split_ff[IDX_W-1:0];
         B_MOVE:    rd_addr = IDX_W'(idx_ff + split_ff);
         default:   rd_addr = idx_ff[IDX_W-1:0];
      endcase
   end
   assign rd_code = codes_mem[rd_addr];
   assign rd_off  = offs_mem[rd_addr];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         codes_mem[wr_addr] <= wr_code;
         offs_mem[wr_addr]  <= wr_off;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE:     if (!q_empty) state_in = B_DISPATCH;
         B_DISPATCH: begin
            unique case (ev_ff.kind)
               EV_START: state_in = B_END;
               EV_PLACE: state_in = active_ff ? B_FILTER : B_END;
               EV_EOD:   state_in = !active_ff ? B_END :
                                    (ev_ff.eod_place ? B_FILTER : B_EODFIN);
               default:  state_in = B_END;
            endcase
         end
         B_FILTER: begin
            priority if (c_ff == CP_BOM || c_ff == CP_CR) state_in = place_done;
            else if (c_ff == CP_LF) state_in = (cursor_ff != 8'd0) ? B_EMIT : place_done;
            else if (ce < CP_SPACE || ce == CP_DEL) state_in = place_done;
            else if (cursor_ff == 8'd0 && (ce == CP_SPACE || ce == CP_IDSP))
               state_in = place_done;
            else if (row_full) state_in = B_EMIT;
            else if (ovf)
               state_in = (is_closing(ce) && fill_ff != '0) ? B_SCANCL : B_SCANOP;
            else state_in = B_LIMIT;
         end
         B_NLDONE: state_in = place_done;
         B_SCANCL: if (!(split_ff != '0 && is_closing(rd_code))) state_in = B_SCANOP;
         B_SCANOP: if (!(split_ff != '0 && is_opening(rd_code))) state_in = B_SUM;
         B_SUM:    if (idx_ff >= fill_ff) state_in = B_DECIDE;
         B_DECIDE: state_in = B_EMIT;
         B_WRAPROW: state_in = wrap_last ? B_WRAPFIN : B_MOVE;
         B_WRAPFIN: state_in = B_FIN;
         B_MOVE:   if (idx_ff >= mv_n) state_in = B_LIMIT;
         B_LIMIT:  state_in = (count_ff >= cfg.limit) ? B_EMIT : place_done;
         B_EMIT: begin
            if (idx_ff == en_ff) state_in = ret_ff;
         end
         B_FIN:    if (can_prod) state_in = place_done;
         B_EODFIN: state_in = active_ff ? B_EMIT : B_END;
         B_END:    if (!hold_v_ff || out_free) state_in = B_IDLE;
         default:  state_in = B_IDLE;
      endcase
   end

   // datapath and result production
   always_comb begin
      ev_in     = ev_ff;
      eod_in    = eod_ff;
      active_in = active_ff;
      cursor_in = cursor_ff;
      count_in  = count_ff;
      row_in    = row_ff;
      fill_in   = fill_ff;
      split_in  = split_ff;
      idx_in    = idx_ff;
      en_in     = en_ff;
      ex_in     = ex_ff;
      moved_in  = moved_ff;
      w_in      = w_ff;
      c_in      = c_ff;
      fnext_in  = fnext_ff;
      ret_in    = ret_ff;
      wr_en     = 1'b0;
      wr_addr   = fill_ff[IDX_W-1:0];
      wr_code   = c_ff;
      wr_off    = ev_ff.char_ofs;
      prod      = 1'b0;
      flush     = 1'b0;
      prod_res  = '{kind: 1'b0, code: rd_code, x: ex_ff + 8'd1, y: ymul[7:0],
                    total: 8'd0, next: '0, last: 1'b0};
      unique case (state_ff)
         B_IDLE: if (!q_empty) ev_in = q_data;
         B_DISPATCH: begin
            unique case (ev_ff.kind)
               EV_START: begin
                  cursor_in = 8'd0; row_in = 4'd0; count_in = 8'd0;
                  fill_in = '0; active_in = 1'b1;
               end
               EV_PLACE: begin eod_in = 1'b0; c_in = ev_ff.code; end
               EV_EOD:   begin eod_in = 1'b1; c_in = CP_REPL; end
               default: begin
               end
            endcase
         end
         B_FILTER: begin
            c_in = ce;
            w_in = cw;
            priority if (c_ff == CP_BOM || c_ff == CP_CR) begin
            end else if (c_ff == CP_LF) begin
               if (cursor_ff != 8'd0) begin
                  en_in = fill_ff; idx_in = '0; ex_in = 8'd0; ret_in = B_NLDONE;
               end
            end else if (ce < CP_SPACE || ce == CP_DEL) begin
            end else if (cursor_ff == 8'd0 && (ce == CP_SPACE || ce == CP_IDSP)) begin
            end else if (row_full) begin
               fnext_in = ev_ff.char_ofs;
               en_in = fill_ff; idx_in = '0; ex_in = 8'd0; ret_in = B_FIN;
            end else if (ovf) begin
               split_in = (is_closing(ce) && fill_ff != '0) ? fill_ff - 1'b1 : fill_ff;
            end
         end
         B_NLDONE: begin
            fill_in = '0; row_in = row_inc; cursor_in = 8'd0;
         end
         B_SCANCL: if (split_ff != '0 && is_closing(rd_code)) split_in = split_ff - 1'b1;
         B_SCANOP: begin
            if (split_ff != '0 && is_opening(rd_code)) split_in = split_ff - 1'b1;
            else begin idx_in = split_ff; moved_in = 9'd0; end
         end
         B_SUM: begin
            if (idx_ff < fill_ff) begin
               moved_in = moved_ff + {5'd0, glyph_w(rd_code)};
               idx_in   = idx_ff + 1'b1;
            end
         end
         B_DECIDE: begin
            split_in = split_dec;
            if (dec_keep) moved_in = 9'd0;
            en_in = split_dec; idx_in = '0; ex_in = 8'd0; ret_in = B_WRAPROW;
         end
         B_WRAPROW: begin
            row_in = row_inc;
            idx_in = '0;
         end
         B_WRAPFIN: begin
            fnext_in = (split_ff < fill_ff) ? rd_off : ev_ff.char_ofs;
            count_in = count_ff - {{(8-FILL_W){1'b0}}, mv_n};
            fill_in  = '0;
         end
         B_MOVE: begin
            if (idx_ff < mv_n) begin
               wr_en   = 1'b1;
               wr_addr = idx_ff[IDX_W-1:0];
               wr_code = rd_code;
               wr_off  = rd_off;
               idx_in  = idx_ff + 1'b1;
            end else begin
               fill_in   = mv_n;
               cursor_in = moved_ff[7:0];
            end
         end
         B_LIMIT: begin
            if (count_ff >= cfg.limit) begin
               fnext_in = ev_ff.char_ofs;
               en_in = fill_ff; idx_in = '0; ex_in = 8'd0; ret_in = B_FIN;
            end else begin
               wr_en     = 1'b1;
               fill_in   = fill_ff + 1'b1;
               count_in  = count_ff + 8'd1;
               cursor_in = cursor_ff + {4'd0, w_ff};
            end
         end
         B_EMIT: begin
            if (idx_ff != en_ff && can_prod) begin
               prod   = 1'b1;
               idx_in = idx_ff + 1'b1;
               ex_in  = ex_ff + {4'd0, glyph_w(rd_code)};
            end
         end
         B_FIN: begin
            if (can_prod) begin
               prod      = 1'b1;
               prod_res  = '{kind: 1'b1, code: 21'd0, x: 8'd0, y: 8'd0,
                             total: count_ff, next: fnext_ff, last: 1'b0};
               fill_in   = '0;
               active_in = 1'b0;
            end
         end
         B_EODFIN: begin
            if (active_ff) begin
               fnext_in = ev_ff.next;
               en_in = fill_ff; idx_in = '0; ex_in = 8'd0; ret_in = B_FIN;
            end
         end
         B_END: if (hold_v_ff && out_free) flush = 1'b1;
         default: begin
         end
      endcase
   end

   // hold stage: a result is marked last once its event is known to be done
   always_comb begin
      rsp_v_in  = rsp_v_ff && !rsp_ready;
      out_in    = out_ff;
      hold_in   = hold_ff;
      hold_v_in = hold_v_ff;
      if (prod) begin
         if (hold_v_ff) begin
            out_in      = hold_ff;
            out_in.last = 1'b0;
            rsp_v_in    = 1'b1;
         end
         hold_in   = prod_res;
         hold_v_in = 1'b1;
      end else if (flush) begin
         out_in      = hold_ff;
         out_in.last = 1'b1;
         rsp_v_in    = 1'b1;
         hold_v_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      ev_ff    <= ev_in;
      eod_ff   <= eod_in;
      ex_ff    <= ex_in;
      split_ff <= split_in;
      idx_ff   <= idx_in;
      en_ff    <= en_in;
      moved_ff <= moved_in;
      w_ff     <= w_in;
      c_ff     <= c_in;
      fnext_ff <= fnext_in;
      ret_ff   <= ret_in;
      hold_ff  <= hold_in;
      out_ff   <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= B_IDLE;
         active_ff <= 1'b0;
         cursor_ff <= 8'd0;
         count_ff  <= 8'd0;
         row_ff    <= 4'd0;
         fill_ff   <= '0;
         hold_v_ff <= 1'b0;
         rsp_v_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         active_ff <= active_in;
         cursor_ff <= cursor_in;
         count_ff  <= count_in;
         row_ff    <= row_in;
         fill_ff   <= fill_in;
         hold_v_ff <= hold_v_in;
         rsp_v_ff  <= rsp_v_in;
      end
   end

   assign rsp_valid       = rsp_v_ff;
   assign rsp_kind        = out_ff.kind;
   assign rsp_glyph_code  = out_ff.code;
   assign rsp_glyph_x     = out_ff.x;
   assign rsp_glyph_y     = out_ff.y;
   assign rsp_glyph_total = out_ff.total;
   assign rsp_next_offset = out_ff.next;
   assign rsp_last        = out_ff.last;

endmodule

`default_nettype wire
